### src/hdma_pkg.sv
// Shared types and constants for the scanline DMA address engine.
// No dependencies; compiled first.
package hdma_pkg;

    localparam int DEF_CHANNELS  = 4;
    localparam int DEF_MAX_UNITS = 16;
    localparam int DEF_ADDR_BITS = 32;
    localparam int RESULT_LIMIT  = 64;
    localparam int UNIT_W        = 5;

    localparam logic [15:0] CW_DEST_FIXED  = 16'h0040;
    localparam logic [15:0] CW_DEST_MASK   = 16'h0060;
    localparam logic [15:0] CW_DEST_RELOAD = 16'h0060;
    localparam logic [15:0] CW_SRC_FIXED   = 16'h0100;
    localparam logic [15:0] CW_WORD        = 16'h0400;

    localparam int STEP_HALF = 2;
    localparam int STEP_WORD = 4;

    typedef enum logic [1:0] {
        OP_ARM    = 2'd0,
        OP_DISARM = 2'd1,
        OP_LINE   = 2'd2,
        OP_FRAME  = 2'd3
    } hdma_op_t;

endpackage

### src/hdma_if.sv
// Request and copy-command channel interfaces (valid/ready).
// Depends on hdma_pkg.
interface hdma_req_if;
    import hdma_pkg::*;
    logic            valid;
    logic            ready;
    hdma_op_t        operation;
    logic [1:0]      channel_sel;
    logic [31:0]     source_address;
    logic [31:0]     dest_address;
    logic [15:0]     control_word;
    logic [UNIT_W-1:0] unit_count;

    modport source (
        output valid, operation, channel_sel, source_address, dest_address,
               control_word, unit_count,
        input  ready
    );
    modport sink (
        input  valid, operation, channel_sel, source_address, dest_address,
               control_word, unit_count,
        output ready
    );
endinterface

interface hdma_cmd_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_address;
    logic [31:0] write_address;
    logic        wide_unit;
    logic [1:0]  channel_index;
    logic        last;

    modport source (
        output valid, read_address, write_address, wide_unit, channel_index, last,
        input  ready
    );
    modport sink (
        input  valid, read_address, write_address, wide_unit, channel_index, last,
        output ready
    );
endinterface

### src/hdma_step_alu.sv
// Shared address stepper: adds the unit size (2 or 4 bytes) modulo 2^ADDR_BITS.
// Depends on hdma_pkg.
module hdma_step_alu #(
    parameter int ADDR_BITS = hdma_pkg::DEF_ADDR_BITS
) (
    input  logic [ADDR_BITS-1:0] addr,
    input  logic                 wide,
    output logic [ADDR_BITS-1:0] sum
);
    import hdma_pkg::*;

    logic [ADDR_BITS-1:0] step;

    assign step = wide ? ADDR_BITS'(STEP_WORD) : ADDR_BITS'(STEP_HALF);
    assign sum  = addr + step;

endmodule

### src/hblank_dma_address_engine_unit.sv
// Top level of the scanline DMA address engine: per-channel pointer state,
// sequencer and copy-command output register. Depends on hdma_pkg, hdma_if,
// hdma_step_alu.
//
//  channel | dir | payload
//  req     | in  | operation, channel_sel, source_address, dest_address,
//          |     | control_word, unit_count
//  cmd     | out | read_address, write_address, wide_unit, channel_index, last
//
// Arm and disarm requests complete in the idle state. A scanline request visits every
// channel in the load step and skips the unarmed ones; each armed channel is loaded,
// runs emit, source step and destination step (on the one shared adder) per command,
// then is saved; hitting the 64-command limit ends it right after that channel's save.
// A frame request rewinds each armed channel in turn. req.ready is low while busy;
// a stalled cmd holds the sequencer in its emit step. No clearing pass.
module hblank_dma_address_engine_unit #(
    parameter int CHANNELS  = hdma_pkg::DEF_CHANNELS,
    parameter int MAX_UNITS = hdma_pkg::DEF_MAX_UNITS,
    parameter int ADDR_BITS = hdma_pkg::DEF_ADDR_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    hdma_req_if.sink      req,
    hdma_cmd_if.source    cmd
);
    import hdma_pkg::*;

    localparam int CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_CW = $clog2(CHANNELS + 1);
    localparam int N_W   = $clog2(RESULT_LIMIT + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EMIT,
        ST_STEP_SRC,
        ST_STEP_DST,
        ST_SAVE,
        ST_REWIND
    } state_t;

    typedef enum logic [1:0] {
        KIND_INC    = 2'd0,
        KIND_FIXED  = 2'd1,
        KIND_RELOAD = 2'd2
    } kind_t;

    state_t               state_reg, state_next;
    logic [CH_CW-1:0]     ch_reg, ch_next;
    logic [UNIT_W-1:0]    unit_reg, unit_next;
    logic [N_W-1:0]       n_reg, n_next;
    logic [CHANNELS-1:0]  armed_reg, armed_next;
    logic                 cmd_valid_reg, cmd_valid_next;

    logic [ADDR_BITS-1:0] src_start_reg [CHANNELS];
    logic [ADDR_BITS-1:0] src_now_reg   [CHANNELS];
    logic [ADDR_BITS-1:0] dst_start_reg [CHANNELS];
    logic [ADDR_BITS-1:0] dst_now_reg   [CHANNELS];
    logic [UNIT_W-1:0]    units_reg     [CHANNELS];
    logic                 word_reg      [CHANNELS];
    logic                 held_reg      [CHANNELS];
    kind_t                kind_reg      [CHANNELS];

    logic [ADDR_BITS-1:0] src_w_reg, dst_w_reg;
    logic [UNIT_W-1:0]    units_w_reg;
    logic                 word_w_reg, held_w_reg;
    kind_t                kind_w_reg;

    logic [31:0]          cmd_rd_reg, cmd_wr_reg;
    logic                 cmd_wide_reg, cmd_last_reg;
    logic [1:0]           cmd_ch_reg;

    logic [CH_IW-1:0]     ch_idx, arm_idx;
    logic                 sel_ok, ch_done, higher_armed, last_cmd;
    logic                 arm_en, load_en, emit_en, src_adv, dst_adv, save_en, rewind_en;
    logic [UNIT_W-1:0]    arm_units;
    logic [15:0]          arm_dm;
    kind_t                arm_kind;
    logic [ADDR_BITS-1:0] alu_in, alu_sum;

    assign ch_idx  = ch_reg[CH_IW-1:0];
    assign arm_idx = CH_IW'(req.channel_sel);
    assign sel_ok  = int'(req.channel_sel) < CHANNELS;
    assign ch_done = ch_reg == CH_CW'(CHANNELS);

    always_comb
    begin
        arm_units = req.unit_count;
        if (arm_units == '0)
            arm_units = UNIT_W'(1);
        else if (int'(arm_units) > MAX_UNITS)
            arm_units = UNIT_W'(MAX_UNITS);
    end

    assign arm_dm = req.control_word & CW_DEST_MASK;

    always_comb
    begin
        if (arm_dm == CW_DEST_FIXED)
            arm_kind = KIND_FIXED;
        else if (arm_dm == CW_DEST_RELOAD)
            arm_kind = KIND_RELOAD;
        else
            arm_kind = KIND_INC;
    end

    always_comb
    begin
        higher_armed = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (i > int'(ch_reg) && armed_reg[i])
                higher_armed = 1'b1;
        end
    end

    assign last_cmd = (n_reg == N_W'(RESULT_LIMIT - 1))
                   || ((unit_reg + UNIT_W'(1)) == units_w_reg && !higher_armed);

    assign alu_in = (state_reg == ST_STEP_SRC) ? src_w_reg : dst_w_reg;

    hdma_step_alu #(
        .ADDR_BITS (ADDR_BITS)
    ) u_step (
        .addr (alu_in),
        .wide (word_w_reg),
        .sum  (alu_sum)
    );

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        unit_next      = unit_reg;
        n_next         = n_reg;
        armed_next     = armed_reg;
        cmd_valid_next = cmd_valid_reg & ~cmd.ready;
        arm_en         = 1'b0;
        load_en        = 1'b0;
        emit_en        = 1'b0;
        src_adv        = 1'b0;
        dst_adv        = 1'b0;
        save_en        = 1'b0;
        rewind_en      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.operation)
                        OP_ARM:
                        begin
                            if (sel_ok)
                            begin
                                arm_en              = 1'b1;
                                armed_next[arm_idx] = 1'b1;
                            end
                        end
                        OP_DISARM:
                        begin
                            if (sel_ok)
                                armed_next[arm_idx] = 1'b0;
                        end
                        OP_LINE:
                        begin
                            ch_next    = '0;
                            n_next     = '0;
                            state_next = ST_LOAD;
                        end
                        OP_FRAME:
                        begin
                            ch_next    = '0;
                            state_next = ST_REWIND;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                if (ch_done)
                    state_next = ST_IDLE;
                else if (armed_reg[ch_idx])
                begin
                    load_en    = 1'b1;
                    unit_next  = '0;
                    state_next = ST_EMIT;
                end
                else
                    ch_next = ch_reg + CH_CW'(1);
            end
            ST_EMIT:
            begin
                if (!cmd_valid_reg || cmd.ready)
                begin
                    emit_en        = 1'b1;
                    cmd_valid_next = 1'b1;
                    n_next         = n_reg + N_W'(1);
                    unit_next      = unit_reg + UNIT_W'(1);
                    state_next     = ST_STEP_SRC;
                end
            end
            ST_STEP_SRC:
            begin
                src_adv    = !held_w_reg;
                state_next = ST_STEP_DST;
            end
            ST_STEP_DST:
            begin
                dst_adv = kind_w_reg != KIND_FIXED;
                if (n_reg == N_W'(RESULT_LIMIT) || unit_reg == units_w_reg)
                    state_next = ST_SAVE;
                else
                    state_next = ST_EMIT;
            end
            ST_SAVE:
            begin
                save_en = 1'b1;
                if (n_reg == N_W'(RESULT_LIMIT))
                    state_next = ST_IDLE;
                else
                begin
                    ch_next    = ch_reg + CH_CW'(1);
                    state_next = ST_LOAD;
                end
            end
            ST_REWIND:
            begin
                if (ch_done)
                    state_next = ST_IDLE;
                else
                begin
                    rewind_en = armed_reg[ch_idx];
                    ch_next   = ch_reg + CH_CW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= '0;
            unit_reg      <= '0;
            n_reg         <= '0;
            armed_reg     <= '0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            unit_reg      <= unit_next;
            n_reg         <= n_next;
            armed_reg     <= armed_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (arm_en)
        begin
            src_start_reg[arm_idx] <= req.source_address[ADDR_BITS-1:0];
            src_now_reg[arm_idx]   <= req.source_address[ADDR_BITS-1:0];
            dst_start_reg[arm_idx] <= req.dest_address[ADDR_BITS-1:0];
            dst_now_reg[arm_idx]   <= req.dest_address[ADDR_BITS-1:0];
            units_reg[arm_idx]     <= arm_units;
            word_reg[arm_idx]      <= (req.control_word & CW_WORD) != '0;
            held_reg[arm_idx]      <= (req.control_word & CW_SRC_FIXED) != '0;
            kind_reg[arm_idx]      <= arm_kind;
        end
        if (load_en)
        begin
            src_w_reg   <= src_now_reg[ch_idx];
            dst_w_reg   <= dst_now_reg[ch_idx];
            units_w_reg <= units_reg[ch_idx];
            word_w_reg  <= word_reg[ch_idx];
            held_w_reg  <= held_reg[ch_idx];
            kind_w_reg  <= kind_reg[ch_idx];
        end
        if (emit_en)
        begin
            cmd_rd_reg   <= 32'(src_w_reg);
            cmd_wr_reg   <= 32'(dst_w_reg);
            cmd_wide_reg <= word_w_reg;
            cmd_ch_reg   <= 2'(ch_reg);
            cmd_last_reg <= last_cmd;
        end
        if (src_adv)
            src_w_reg <= alu_sum;
        if (dst_adv)
            dst_w_reg <= alu_sum;
        if (save_en)
        begin
            src_now_reg[ch_idx] <= src_w_reg;
            dst_now_reg[ch_idx] <= (kind_w_reg == KIND_RELOAD) ? dst_start_reg[ch_idx]
                                                                : dst_w_reg;
        end
        if (rewind_en)
        begin
            src_now_reg[ch_idx] <= src_start_reg[ch_idx];
            dst_now_reg[ch_idx] <= dst_start_reg[ch_idx];
        end
    end

    assign req.ready         = state_reg == ST_IDLE;
    assign cmd.valid         = cmd_valid_reg;
    assign cmd.read_address  = cmd_rd_reg;
    assign cmd.write_address = cmd_wr_reg;
    assign cmd.wide_unit     = cmd_wide_reg;
    assign cmd.channel_index = cmd_ch_reg;
    assign cmd.last          = cmd_last_reg;

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> unit_reg < units_w_reg && units_w_reg != '0)
        else $error("emit past channel unit count");

    a_limit: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= N_W'(RESULT_LIMIT))
        else $error("command count over limit");

    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("command raised outside emit");

    a_step_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STEP_DST |-> $past(state_reg == ST_STEP_SRC))
        else $error("destination step without source step");

endmodule

### verif/hdma_copy_checker.sv
// Copy-command checker for the scanline DMA address engine: watches the request
// and command channels, predicts the commands and compares them field by field.
// Depends on hdma_pkg and hdma_if.
`timescale 1ns / 1ps

module hdma_copy_checker #(
    parameter int CHANNELS  = hdma_pkg::DEF_CHANNELS,
    parameter int MAX_UNITS = hdma_pkg::DEF_MAX_UNITS,
    parameter int ADDR_BITS = hdma_pkg::DEF_ADDR_BITS
) (
    input  logic  clk,
    input  logic  rst_n,
    hdma_req_if   req,
    hdma_cmd_if   cmd,
    output int    mismatches,
    output int    outstanding
);
    import hdma_pkg::*;

    localparam logic [31:0] ADDR_MASK = 32'hFFFF_FFFF >> (32 - ADDR_BITS);

    typedef enum logic [1:0] {
        DST_INC    = 2'd0,
        DST_FIXED  = 2'd1,
        DST_RELOAD = 2'd2
    } dst_mode_t;

    typedef struct packed {
        logic [31:0] read_address;
        logic [31:0] write_address;
        logic        wide_unit;
        logic [1:0]  channel_index;
        logic        last;
    } copy_cmd_t;

    logic        ch_armed   [CHANNELS];
    logic [31:0] src_base   [CHANNELS];
    logic [31:0] src_ptr    [CHANNELS];
    logic [31:0] dst_base   [CHANNELS];
    logic [31:0] dst_ptr    [CHANNELS];
    int          line_units [CHANNELS];
    logic        word_units [CHANNELS];
    logic        src_hold   [CHANNELS];
    dst_mode_t   dst_mode   [CHANNELS];

    copy_cmd_t pending_copies[$];
    int        fail_count = 0;
    int        queue_depth = 0;

    assign mismatches  = fail_count;
    assign outstanding = queue_depth;

    task automatic arm_channel(input int ch);
        logic [15:0] dm;
        int          cnt;
        dm  = req.control_word & CW_DEST_MASK;
        cnt = req.unit_count;
        if (cnt == 0)
            cnt = 1;
        if (cnt > MAX_UNITS)
            cnt = MAX_UNITS;
        ch_armed[ch]   = 1'b1;
        src_base[ch]   = req.source_address & ADDR_MASK;
        src_ptr[ch]    = req.source_address & ADDR_MASK;
        dst_base[ch]   = req.dest_address & ADDR_MASK;
        dst_ptr[ch]    = req.dest_address & ADDR_MASK;
        line_units[ch] = cnt;
        word_units[ch] = (req.control_word & CW_WORD) != 16'h0;
        src_hold[ch]   = (req.control_word & CW_SRC_FIXED) != 16'h0;
        if (dm == CW_DEST_FIXED)
            dst_mode[ch] = DST_FIXED;
        else if (dm == CW_DEST_RELOAD)
            dst_mode[ch] = DST_RELOAD;
        else
            dst_mode[ch] = DST_INC;
    endtask

    task automatic run_scanline();
        copy_cmd_t   c;
        logic [31:0] dst;
        logic [31:0] step;
        int          total;
        int          n;
        total = 0;
        n     = 0;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            if (ch_armed[ch])
                total += line_units[ch];
        end
        if (total > RESULT_LIMIT)
            total = RESULT_LIMIT;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            if (ch_armed[ch])
            begin
                dst  = dst_ptr[ch];
                step = word_units[ch] ? STEP_WORD : STEP_HALF;
                for (int i = 0; i < line_units[ch] && n < RESULT_LIMIT; i++)
                begin
                    c.read_address  = src_ptr[ch];
                    c.write_address = dst;
                    c.wide_unit     = word_units[ch];
                    c.channel_index = ch[1:0];
                    c.last          = (n == total - 1);
                    pending_copies.push_back(c);
                    n++;
                    if (!src_hold[ch])
                        src_ptr[ch] = (src_ptr[ch] + step) & ADDR_MASK;
                    if (dst_mode[ch] != DST_FIXED)
                        dst = (dst + step) & ADDR_MASK;
                end
                dst_ptr[ch] = (dst_mode[ch] == DST_RELOAD) ? dst_base[ch] : dst;
            end
        end
    endtask

    task automatic check_copy();
        copy_cmd_t want;
        if (pending_copies.size() == 0)
        begin
            $error("unexpected copy command: read_address %h write_address %h channel %0d",
                   cmd.read_address, cmd.write_address, cmd.channel_index);
            fail_count++;
        end
        else
        begin
            want = pending_copies.pop_front();
            if (cmd.read_address !== want.read_address)
            begin
                $error("read_address mismatch: expected %h, actual %h",
                       want.read_address, cmd.read_address);
                fail_count++;
            end
            if (cmd.write_address !== want.write_address)
            begin
                $error("write_address mismatch: expected %h, actual %h",
                       want.write_address, cmd.write_address);
                fail_count++;
            end
            if (cmd.wide_unit !== want.wide_unit)
            begin
                $error("wide_unit mismatch: expected %0d, actual %0d",
                       want.wide_unit, cmd.wide_unit);
                fail_count++;
            end
            if (cmd.channel_index !== want.channel_index)
            begin
                $error("channel_index mismatch: expected %0d, actual %0d",
                       want.channel_index, cmd.channel_index);
                fail_count++;
            end
            if (cmd.last !== want.last)
            begin
                $error("last mismatch: expected %0d, actual %0d", want.last, cmd.last);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                ch_armed[ch] = 1'b0;
            end
            pending_copies.delete();
            queue_depth = 0;
        end
        else
        begin
            if (cmd.valid === 1'b1 && cmd.ready === 1'b1)
                check_copy();
            if (req.valid === 1'b1 && req.ready === 1'b1)
            begin
                case (req.operation)
                    OP_ARM:
                    begin
                        if (req.channel_sel < CHANNELS)
                            arm_channel(req.channel_sel);
                    end
                    OP_DISARM:
                    begin
                        if (req.channel_sel < CHANNELS)
                            ch_armed[req.channel_sel] = 1'b0;
                    end
                    OP_FRAME:
                    begin
                        for (int ch = 0; ch < CHANNELS; ch++)
                        begin
                            if (ch_armed[ch])
                            begin
                                src_ptr[ch] = src_base[ch];
                                dst_ptr[ch] = dst_base[ch];
                            end
                        end
                    end
                    default:
                        run_scanline();
                endcase
            end
            queue_depth = pending_copies.size();
        end
    end

endmodule

### verif/hblank_dma_address_engine_unit_tb.sv
// Testbench top for hblank_dma_address_engine_unit: clock, reset, request
// stimulus, command back-pressure, watchdog and verdict.
// Depends on hdma_pkg, hdma_if, the engine RTL and hdma_copy_checker.
`timescale 1ns / 1ps

module hblank_dma_address_engine_unit_tb;
    import hdma_pkg::*;

    localparam int RANDOM_REQUESTS = 350;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 40;

    logic clk;
    logic rst_n;
    bit   quiet_run;
    int   sent_items;
    int   stall_cycles;
    int   mismatches;
    int   outstanding;

    hdma_req_if req_bus ();
    hdma_cmd_if cmd_bus ();

    hblank_dma_address_engine_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .cmd   (cmd_bus)
    );

    hdma_copy_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_bus),
        .cmd         (cmd_bus),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cmd_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cmd_bus.ready <= quiet_run || ($urandom_range(0, 99) >= 16);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (cmd_bus.valid && cmd_bus.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_request(input hdma_op_t op, input logic [1:0] ch,
                                input logic [31:0] src, input logic [31:0] dst,
                                input logic [15:0] cw, input logic [4:0] cnt);
        while (!quiet_run && $urandom_range(0, 99) < 16)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid          <= 1'b1;
        req_bus.operation      <= op;
        req_bus.channel_sel    <= ch;
        req_bus.source_address <= src;
        req_bus.dest_address   <= dst;
        req_bus.control_word   <= cw;
        req_bus.unit_count     <= cnt;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        sent_items++;
        quiet_run = (sent_items >= 150 && sent_items < 230);
    endtask

    function automatic logic [31:0] pick_address();
        if ($urandom_range(0, 7) == 0)
            return 32'hFFFF_FFC0 | $urandom_range(0, 63);
        return $urandom;
    endfunction

    task automatic send_random();
        int          r;
        hdma_op_t    op;
        logic [4:0]  cnt;
        r = $urandom_range(0, 99);
        if (r < 30)
            op = OP_ARM;
        else if (r < 40)
            op = OP_DISARM;
        else if (r < 85)
            op = OP_LINE;
        else
            op = OP_FRAME;
        if ($urandom_range(0, 5) == 0)
            cnt = 5'($urandom_range(17, 31));
        else
            cnt = 5'($urandom_range(0, 16));
        send_request(op, 2'($urandom_range(0, 3)), pick_address(), pick_address(),
                     16'($urandom_range(0, 65535)), cnt);
    endtask

    initial
    begin
        rst_n                  <= 1'b0;
        req_bus.valid          <= 1'b0;
        req_bus.operation      <= OP_ARM;
        req_bus.channel_sel    <= 2'd0;
        req_bus.source_address <= 32'h0;
        req_bus.dest_address   <= 32'h0;
        req_bus.control_word   <= 16'h0;
        req_bus.unit_count     <= 5'd0;
        quiet_run  = 1'b0;
        sent_items = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // nothing armed yet
        send_request(OP_LINE, 2'd0, 32'h0, 32'h0, 16'h0, 5'd0);
        send_request(OP_FRAME, 2'd0, 32'h0, 32'h0, 16'h0, 5'd0);
        // zero count, wrapping increment addresses
        send_request(OP_ARM, 2'd0, 32'hFFFF_FFFC, 32'hFFFF_FFFE, 16'h0, 5'd0);
        send_request(OP_ARM, 2'd1, 32'h0, 32'h0000_1000, CW_WORD | CW_DEST_FIXED, 5'd16);
        send_request(OP_ARM, 2'd2, 32'h0000_2000, 32'h0000_3000,
                     CW_SRC_FIXED | CW_DEST_RELOAD, 5'd31);
        // decrement code behaves as increment; count clamps
        send_request(OP_ARM, 2'd3, 32'h0000_4000, 32'h0000_5000, CW_WORD | 16'h0020, 5'd17);
        send_request(OP_LINE, 2'd0, 32'h0, 32'h0, 16'h0, 5'd0);
        send_request(OP_LINE, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 5'd31);
        send_request(OP_FRAME, 2'd1, 32'h0, 32'h0, 16'h0, 5'd0);
        send_request(OP_LINE, 2'd0, 32'h0, 32'h0, 16'h0, 5'd0);
        // re-arm with every control bit set
        send_request(OP_ARM, 2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 5'd1);
        send_request(OP_DISARM, 2'd1, 32'h0, 32'h0, 16'h0, 5'd0);
        send_request(OP_LINE, 2'd0, 32'h0, 32'h0, 16'h0, 5'd0);
        send_request(OP_DISARM, 2'd0, 32'h0, 32'h0, 16'h0, 5'd0);
        send_request(OP_DISARM, 2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 5'd31);
        send_request(OP_DISARM, 2'd3, 32'h0, 32'h0, 16'h0, 5'd0);
        send_request(OP_LINE, 2'd0, 32'h0, 32'h0, 16'h0, 5'd0);
        send_request(OP_ARM, 2'd3, 32'h0, 32'h0, 16'h0, 5'd16);
        send_request(OP_LINE, 2'd0, 32'h0, 32'h0, 16'h0, 5'd0);
        send_request(OP_FRAME, 2'd0, 32'h0, 32'h0, 16'h0, 5'd0);
        send_request(OP_LINE, 2'd0, 32'h0, 32'h0, 16'h0, 5'd0);
        send_request(OP_DISARM, 2'd3, 32'h0, 32'h0, 16'h0, 5'd0);

        repeat (RANDOM_REQUESTS) send_random();

        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
